>>> rtl/c3e_pkg.sv
// shared types and constants of the 3x3 edge-replicating convolution block
package c3e_pkg;

	localparam int PIX_W     = 8;
	localparam int TAP_W     = 8;
	localparam int COEFF_W   = 3 * TAP_W;
	localparam int ROW_SUM_W = 18;
	localparam int SUM_W     = 20;
	localparam int SCALE_W   = 32;
	localparam int BIAS_W    = 21;
	localparam int PROD_W    = SUM_W + SCALE_W;
	localparam int VAL_W     = PROD_W + 1;
	localparam int FRAC_W    = 24;
	localparam int BIAS_SHIFT = 16;
	localparam int CLAMP_W   = FRAC_W + PIX_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CLAMP_W-1:0] CLAMP_TOP = CLAMP_W'(255) << FRAC_W;
	localparam logic [FRAC_W-1:0]  FRAC_HALF = FRAC_W'(1) << (FRAC_W - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_TOP = 3'd0,
		REG_COEFF_MID = 3'd1,
		REG_COEFF_BOT = 3'd2,
		REG_SCALE     = 3'd3,
		REG_BIAS      = 3'd4,
		REG_SATURATE  = 3'd5,
		REG_MAX_VALUE = 3'd6
	} cfg_reg_t;

	// packed so that top sits in the low byte
	typedef struct packed {
		logic [PIX_W-1:0] bot;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] top;
	} column_t;

	typedef struct packed {
		logic signed [SCALE_W-1:0] scale;
		logic signed [BIAS_W-1:0]  bias;
		logic                      saturate_mode;
		logic [PIX_W-1:0]          max_value;
	} cfg_post_t;

	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

endpackage

>>> rtl/c3e_in_if.sv
// column channel: three vertically adjacent pixels and an end-of-row mark
interface c3e_in_if;
	import c3e_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pix_top;
	logic [PIX_W-1:0] pix_mid;
	logic [PIX_W-1:0] pix_bot;
	logic             last_in_row;

	modport source (output valid, output pix_top, output pix_mid, output pix_bot,
		output last_in_row, input ready);
	modport sink (input valid, input pix_top, input pix_mid, input pix_bot,
		input last_in_row, output ready);
endinterface

>>> rtl/c3e_out_if.sv
// pixel channel: filtered pixel and last-of-row mark
interface c3e_out_if;
	import c3e_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             row_end;

	modport source (output valid, output pixel_out, output row_end, input ready);
	modport sink (input valid, input pixel_out, input row_end, output ready);
endinterface

>>> rtl/conv3x3_byte_edge_replicate_core.sv
// top level of the 3x3 edge-replicating convolution block
// Usage:
//  columns carries one column per item: pixels of the row above, the current row and the row
//  below, plus last_in_row on the final column of a row. pixels carries filtered pixels, with
//  row_end on the last pixel of each row. Both are valid/ready channels.
//  The first column of a row yields no pixel; every later column yields the pixel of the
//  column before it, and the last column also yields its own pixel afterwards, so the column
//  channel drops ready at each row end until that pixel is issued. A one-column row yields one.
//  Throughput is one column per cycle while the pixel channel does not stall, bar row ends.
//  Each pixel travels from the accepted column to the pixel channel
//  through six register stages: window select, three row lanes with their taps, lane merge
//  with the scale multiplier, bias add, magnitude and clamp, rounding and cap.
//  When the receiver stalls, the six stages keep filling; ready drops once all are full.
//  Reset empties the pipeline, starts a new row and loads the register defaults.
//  Registers are written via cfg_we/cfg_idx/cfg_data while the block is idle, a user rule the block does not enforce.
module conv3x3_byte_edge_replicate_core (
	input  logic                             clk,
	input  logic                             arst_n,
	c3e_in_if.sink                           columns,
	c3e_out_if.source                        pixels,
	input  logic                             cfg_we,
	input  logic [c3e_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [c3e_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import c3e_pkg::*;

	logic [COEFF_W-1:0]        coeff_top_q, coeff_mid_q, coeff_bot_q;
	logic signed [SCALE_W-1:0] scale_q;
	logic signed [BIAS_W-1:0]  bias_q;
	logic                      saturate_q;
	logic [PIX_W-1:0]          max_value_q;

	logic    first_q, pend_q;
	column_t col_prev_q, col_pp_q;
	column_t col_in;
	logic    accept, issue;
	column_t win_l, win_m, win_r;
	logic    win_row_end;

	column_t left_s1, mid_s1, right_s1;
	logic    valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic    row_end_s1, row_end_s2, row_end_s3, row_end_s4, row_end_s5, row_end_s6;
	logic    rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic signed [ROW_SUM_W-1:0] sum_top_s2, sum_mid_s2, sum_bot_s2;
	stage_en_t                   merge_en;
	cfg_post_t                   post;
	logic [PIX_W-1:0]            pixel_s6;
	logic                        lane_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_top_q <= '0;
			coeff_mid_q <= COEFF_W'(24'h000100);
			coeff_bot_q <= '0;
			scale_q     <= SCALE_W'(32'h0100_0000);
			bias_q      <= '0;
			saturate_q  <= 1'b1;
			max_value_q <= '1;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_COEFF_TOP: coeff_top_q <= cfg_data[COEFF_W-1:0];
				REG_COEFF_MID: coeff_mid_q <= cfg_data[COEFF_W-1:0];
				REG_COEFF_BOT: coeff_bot_q <= cfg_data[COEFF_W-1:0];
				REG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				REG_BIAS:      bias_q      <= cfg_data[BIAS_W-1:0];
				REG_SATURATE:  saturate_q  <= cfg_data[0];
				REG_MAX_VALUE: max_value_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// stage takes a new item when empty or when its own item moves on
	assign rdy6 = !valid_s6 || pixels.ready;
	assign rdy5 = !valid_s5 || rdy6;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign columns.ready = rdy1 && !pend_q;
	assign accept        = columns.valid && columns.ready;
	assign col_in        = '{bot: columns.pix_bot, mid: columns.pix_mid, top: columns.pix_top};
	// the first column of a longer row only fills the window
	assign issue = pend_q || (accept && !(first_q && !columns.last_in_row));

	always_comb begin
		if (pend_q) begin
			win_l       = col_pp_q;
			win_m       = col_prev_q;
			win_r       = col_prev_q;
			win_row_end = 1'b1;
		end else if (first_q) begin
			win_l       = col_in;
			win_m       = col_in;
			win_r       = col_in;
			win_row_end = 1'b1;
		end else begin
			win_l       = col_pp_q;
			win_m       = col_prev_q;
			win_r       = col_in;
			win_row_end = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			pend_q  <= 1'b0;
		end else begin
			if (pend_q && rdy1) begin
				pend_q <= 1'b0;
			end
			if (accept && first_q && !columns.last_in_row) begin
				first_q <= 1'b0;
			end
			if (accept && !first_q && columns.last_in_row) begin
				first_q <= 1'b1;
				pend_q  <= 1'b1;
			end
		end
	end

	// at row end the last column shifts in, so the second pixel reuses the stored pair
	always_ff @(posedge clk) begin
		if (accept) begin
			if (first_q) begin
				if (!columns.last_in_row) begin
					col_pp_q   <= col_in;
					col_prev_q <= col_in;
				end
			end else begin
				col_pp_q   <= col_prev_q;
				col_prev_q <= col_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= issue;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
		end
	end

	assign lane_en     = rdy2 && valid_s1;
	assign merge_en.s3 = rdy3 && valid_s2;
	assign merge_en.s4 = rdy4 && valid_s3;
	assign merge_en.s5 = rdy5 && valid_s4;
	assign merge_en.s6 = rdy6 && valid_s5;

	always_ff @(posedge clk) begin
		if (rdy1 && issue) begin
			left_s1    <= win_l;
			mid_s1     <= win_m;
			right_s1   <= win_r;
			row_end_s1 <= win_row_end;
		end
		if (lane_en)     row_end_s2 <= row_end_s1;
		if (merge_en.s3) row_end_s3 <= row_end_s2;
		if (merge_en.s4) row_end_s4 <= row_end_s3;
		if (merge_en.s5) row_end_s5 <= row_end_s4;
		if (merge_en.s6) row_end_s6 <= row_end_s5;
	end

	c3e_lane u_lane_top (
		.clk        (clk),
		.en         (lane_en),
		.taps       (coeff_top_q),
		.pix_left   (left_s1.top),
		.pix_mid    (mid_s1.top),
		.pix_right  (right_s1.top),
		.row_sum_s2 (sum_top_s2)
	);

	c3e_lane u_lane_mid (
		.clk        (clk),
		.en         (lane_en),
		.taps       (coeff_mid_q),
		.pix_left   (left_s1.mid),
		.pix_mid    (mid_s1.mid),
		.pix_right  (right_s1.mid),
		.row_sum_s2 (sum_mid_s2)
	);

	c3e_lane u_lane_bot (
		.clk        (clk),
		.en         (lane_en),
		.taps       (coeff_bot_q),
		.pix_left   (left_s1.bot),
		.pix_mid    (mid_s1.bot),
		.pix_right  (right_s1.bot),
		.row_sum_s2 (sum_bot_s2)
	);

	assign post = '{scale: scale_q, bias: bias_q, saturate_mode: saturate_q,
		max_value: max_value_q};

	c3e_merge u_merge (
		.clk        (clk),
		.en         (merge_en),
		.post       (post),
		.sum_top_s2 (sum_top_s2),
		.sum_mid_s2 (sum_mid_s2),
		.sum_bot_s2 (sum_bot_s2),
		.pixel_s6   (pixel_s6)
	);

	assign pixels.valid     = valid_s6;
	assign pixels.pixel_out = pixel_s6;
	assign pixels.row_end   = row_end_s6;

`ifndef NO_ASSERTIONS
	// end of a longer row: interior pixel goes out now, the closing pixel is queued
	a_row_end_split: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !first_q && columns.last_in_row |=> pend_q && valid_s1 && !row_end_s1)
		else $error("row end did not queue the closing pixel");

	a_pend_issue: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && rdy1 |=> valid_s1 && row_end_s1 && !pend_q)
		else $error("queued closing pixel not issued with row end");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !rdy5 |=> valid_s5)
		else $error("blocked pipeline stage lost its item");
`endif
endmodule

>>> rtl/c3e_lane.sv
// one row lane: three signed taps against three pixels, registered row sum
module c3e_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic [c3e_pkg::COEFF_W-1:0]         taps,
	input  logic [c3e_pkg::PIX_W-1:0]           pix_left,
	input  logic [c3e_pkg::PIX_W-1:0]           pix_mid,
	input  logic [c3e_pkg::PIX_W-1:0]           pix_right,
	output logic signed [c3e_pkg::ROW_SUM_W-1:0] row_sum_s2
);
	import c3e_pkg::*;

	localparam int MUL_W = TAP_W + PIX_W + 1;

	logic signed [TAP_W-1:0] tap_l, tap_m, tap_r;
	logic signed [MUL_W-1:0] prod_l, prod_m, prod_r;

	assign tap_l = taps[TAP_W-1:0];
	assign tap_m = taps[2*TAP_W-1:TAP_W];
	assign tap_r = taps[3*TAP_W-1:2*TAP_W];

	// pixels are unsigned, so a zero sign bit goes in front
	assign prod_l = MUL_W'(tap_l) * MUL_W'($signed({1'b0, pix_left}));
	assign prod_m = MUL_W'(tap_m) * MUL_W'($signed({1'b0, pix_mid}));
	assign prod_r = MUL_W'(tap_r) * MUL_W'($signed({1'b0, pix_right}));

	always_ff @(posedge clk) begin
		if (en) begin
			row_sum_s2 <= ROW_SUM_W'(prod_l) + ROW_SUM_W'(prod_m) + ROW_SUM_W'(prod_r);
		end
	end
endmodule

>>> rtl/c3e_merge.sv
// merge of the row lanes: total, scale, bias, magnitude and clamp, rounding and cap
module c3e_merge (
	input  logic                                 clk,
	input  c3e_pkg::stage_en_t                   en,
	input  c3e_pkg::cfg_post_t                   post,
	input  logic signed [c3e_pkg::ROW_SUM_W-1:0] sum_top_s2,
	input  logic signed [c3e_pkg::ROW_SUM_W-1:0] sum_mid_s2,
	input  logic signed [c3e_pkg::ROW_SUM_W-1:0] sum_bot_s2,
	output logic [c3e_pkg::PIX_W-1:0]            pixel_s6
);
	import c3e_pkg::*;

	logic signed [SUM_W-1:0]  sum;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [VAL_W-1:0]  bias_q24;
	logic signed [VAL_W-1:0]  val_s4;
	logic signed [VAL_W-1:0]  mag;
	logic [CLAMP_W-1:0]       clamped;
	logic [CLAMP_W-1:0]       clamped_s5;
	logic [PIX_W-1:0]         whole;
	logic [FRAC_W-1:0]        frac;
	logic                     round_up;
	logic [PIX_W:0]           rounded;
	logic [PIX_W-1:0]         capped;

	assign sum  = SUM_W'(sum_top_s2) + SUM_W'(sum_mid_s2) + SUM_W'(sum_bot_s2);
	assign prod = sum * post.scale;

	assign bias_q24 = VAL_W'(post.bias) <<< BIAS_SHIFT;

	always_comb begin
		mag = val_s4;
		if (!post.saturate_mode && val_s4 < 0) begin
			mag = -val_s4;
		end
		if (mag < 0) begin
			clamped = '0;
		end else if (mag > $signed({1'b0, VAL_W'(CLAMP_TOP)})) begin
			clamped = CLAMP_TOP;
		end else begin
			clamped = mag[CLAMP_W-1:0];
		end
	end

	// round half to even on the 24 fraction bits
	assign whole    = clamped_s5[CLAMP_W-1:FRAC_W];
	assign frac     = clamped_s5[FRAC_W-1:0];
	assign round_up = (frac > FRAC_HALF) || (frac == FRAC_HALF && whole[0]);
	assign rounded  = {1'b0, whole} + {{PIX_W{1'b0}}, round_up};
	assign capped   = (rounded > {1'b0, post.max_value}) ? post.max_value : rounded[PIX_W-1:0];

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3 <= prod;
		end
		if (en.s4) begin
			val_s4 <= VAL_W'(prod_s3) + bias_q24;
		end
		if (en.s5) begin
			clamped_s5 <= clamped;
		end
		if (en.s6) begin
			pixel_s6 <= capped;
		end
	end
endmodule
